// ----- sv/rgbds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rgbds_pkg;

  // configuration port geometry
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  // register reset values
  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 11'd160;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 11'd120;
  localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 11'd96;
  localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 11'd96;

  // result coordinate width
  localparam int unsigned COORD_W = 10;

  // source pixel request
  typedef struct packed {
    logic [15:0] pixel;
  } pix_t;

  // destination pixel request
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               frame_end;
  } rgb_t;

  // keep decision for the pixel at the input
  typedef struct packed {
    logic               keep;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } dec_t;

endpackage

`default_nettype wire

// ----- sv/rgbds_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rgbds_pix_if;
  import rgbds_pkg::*;

  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/rgbds_rgb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rgbds_rgb_if;
  import rgbds_pkg::*;

  logic valid;
  logic ready;
  rgb_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/rgbds_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rgbds_cfg #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned SZW_W     = $clog2(MAX_WIDTH + 1),
  localparam int unsigned SZH_W     = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rgbds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rgbds_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                               restart_o,
  output logic [SZW_W-1:0]                   src_w_o,
  output logic [SZH_W-1:0]                   src_h_o,
  output logic [SZW_W-1:0]                   dst_w_o,
  output logic [SZH_W-1:0]                   dst_h_o
);
  import rgbds_pkg::*;

  logic [CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [31:0]      sw_raw, sh_raw, dw_raw, dh_raw;
  logic [31:0]      sw_eff, sh_eff, dw_eff, dh_eff;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RST_SRC_WIDTH;
      src_h_q <= RST_SRC_HEIGHT;
      dst_w_q <= RST_DST_WIDTH;
      dst_h_q <= RST_DST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // any write to a known register restarts the frame
  always_comb begin
    restart_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT: restart_o = 1'b1;
        default: restart_o = 1'b0;
      endcase
    end
  end

  // effective sizes: zero acts as one, source capped at max, target capped at source
  always_comb begin
    sw_raw = 32'(src_w_q);
    sh_raw = 32'(src_h_q);
    dw_raw = 32'(dst_w_q);
    dh_raw = 32'(dst_h_q);

    if (sw_raw == 32'd0)                  sw_eff = 32'd1;
    else if (sw_raw > 32'(MAX_WIDTH))     sw_eff = 32'(MAX_WIDTH);
    else                                  sw_eff = sw_raw;

    if (sh_raw == 32'd0)                  sh_eff = 32'd1;
    else if (sh_raw > 32'(MAX_HEIGHT))    sh_eff = 32'(MAX_HEIGHT);
    else                                  sh_eff = sh_raw;

    if (dw_raw == 32'd0)                  dw_eff = 32'd1;
    else if (dw_raw > sw_eff)             dw_eff = sw_eff;
    else                                  dw_eff = dw_raw;

    if (dh_raw == 32'd0)                  dh_eff = 32'd1;
    else if (dh_raw > sh_eff)             dh_eff = sh_eff;
    else                                  dh_eff = dh_raw;
  end

  assign src_w_o = SZW_W'(sw_eff);
  assign src_h_o = SZH_W'(sh_eff);
  assign dst_w_o = SZW_W'(dw_eff);
  assign dst_h_o = SZH_W'(dh_eff);

endmodule

`default_nettype wire

// ----- sv/rgbds_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rgbds_ctrl #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned SZW_W     = $clog2(MAX_WIDTH + 1),
  localparam int unsigned SZH_W     = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned ACW_W     = $clog2(MAX_WIDTH * MAX_WIDTH + 1),
  localparam int unsigned ACH_W     = $clog2(MAX_HEIGHT * MAX_HEIGHT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                restart_i,
  input  logic [SZW_W-1:0]    src_w_i,
  input  logic [SZH_W-1:0]    src_h_i,
  input  logic [SZW_W-1:0]    dst_w_i,
  input  logic [SZH_W-1:0]    dst_h_i,
  output rgbds_pkg::dec_t     dec_o
);
  import rgbds_pkg::*;

  logic [SZW_W-1:0] src_col_q, src_col_d, dst_col_q, dst_col_d;
  logic [SZH_W-1:0] src_row_q, src_row_d, dst_row_q, dst_row_d;
  logic [ACW_W-1:0] col_tgt_q, col_tgt_d, col_src_q, col_src_d;
  logic [ACH_W-1:0] row_tgt_q, row_tgt_d, row_src_q, row_src_d;
  logic             row_sel, keep, row_end, frame_last;

  // nearest-neighbor selection from the running accumulators
  always_comb begin
    row_sel = (dst_row_q < dst_h_i) &&
              ({1'b0, row_tgt_q} < ({1'b0, row_src_q} + (ACH_W + 1)'(dst_h_i)));
    keep    = row_sel && (dst_col_q < dst_w_i) &&
              ({1'b0, col_tgt_q} < ({1'b0, col_src_q} + (ACW_W + 1)'(dst_w_i)));
    row_end    = (src_col_q >= (src_w_i - SZW_W'(1)));
    frame_last = (src_row_q >= (src_h_i - SZH_W'(1)));
  end

  assign dec_o.keep      = keep;
  assign dec_o.col       = COORD_W'(dst_col_q);
  assign dec_o.row       = COORD_W'(dst_row_q);
  assign dec_o.frame_end = (dst_col_q == (dst_w_i - SZW_W'(1))) &&
                           (dst_row_q == (dst_h_i - SZH_W'(1)));

  // counter and accumulator update per accepted pixel; a restart clears them all
  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    col_tgt_d = col_tgt_q;
    col_src_d = col_src_q;
    row_tgt_d = row_tgt_q;
    row_src_d = row_src_q;

    if (restart_i) begin
      src_col_d = '0;
      src_row_d = '0;
      dst_col_d = '0;
      dst_row_d = '0;
      col_tgt_d = '0;
      col_src_d = '0;
      row_tgt_d = '0;
      row_src_d = '0;
    end else if (accept_i) begin
      if (keep) begin
        dst_col_d = dst_col_q + SZW_W'(1);
        col_tgt_d = col_tgt_q + ACW_W'(src_w_i);
      end
      if (row_end) begin
        src_col_d = '0;
        dst_col_d = '0;
        col_tgt_d = '0;
        col_src_d = '0;
        if (frame_last) begin
          src_row_d = '0;
          dst_row_d = '0;
          row_tgt_d = '0;
          row_src_d = '0;
        end else begin
          if (row_sel) begin
            dst_row_d = dst_row_q + SZH_W'(1);
            row_tgt_d = row_tgt_q + ACH_W'(src_h_i);
          end
          src_row_d = src_row_q + SZH_W'(1);
          row_src_d = row_src_q + ACH_W'(dst_h_i);
        end
      end else begin
        src_col_d = src_col_q + SZW_W'(1);
        col_src_d = col_src_q + ACW_W'(dst_w_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      col_tgt_q <= '0;
      col_src_q <= '0;
      row_tgt_q <= '0;
      row_src_q <= '0;
    end else begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      col_tgt_q <= col_tgt_d;
      col_src_q <= col_src_d;
      row_tgt_q <= row_tgt_d;
      row_src_q <= row_src_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rgbds_out.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rgbds_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  rgbds_pkg::pix_t    pix_i,
  input  rgbds_pkg::dec_t    dec_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rgbds_pkg::rgb_t    out_data_o
);
  import rgbds_pkg::*;

  logic valid_q, valid_d;
  logic load;
  rgb_t data_q, data_d;

  // a kept pixel loads the result register, which frees as it is taken
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = accept_i && dec_i.keep;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // rgb565 widened to 8 bits per channel, low bits zero
  always_comb begin
    data_d.red       = {pix_i.pixel[15:11], 3'b000};
    data_d.green     = {pix_i.pixel[10:5], 2'b00};
    data_d.blue      = {pix_i.pixel[4:0], 3'b000};
    data_d.out_col   = dec_i.col;
    data_d.out_row   = dec_i.row;
    data_d.frame_end = dec_i.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- sv/rgb565_nearest_downscaler.sv -----
// a kept pixel shows at the output in the cycle after its request is taken
// throughput: one source pixel per cycle; the single result register frees as it is read
// dropped pixels produce no result, but an unread result holds off every input request
// reset: asynchronous, active low; sizes return to 160x120 -> 96x96, counters clear
// a write to any size register restarts the frame at the next pixel
`timescale 1ns / 1ps
`default_nettype none

module rgb565_nearest_downscaler #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgbds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgbds_pkg::CFG_W-1:0]     cfg_data_i,
  rgbds_pix_if.sink                       pix_i,
  rgbds_rgb_if.source                     rgb_o
);
  import rgbds_pkg::*;

  localparam int unsigned SZW_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SZH_W = $clog2(MAX_HEIGHT + 1);

  logic             restart;
  logic [SZW_W-1:0] src_w, dst_w;
  logic [SZH_W-1:0] src_h, dst_h;
  logic             accept;
  logic             in_ready;
  dec_t             dec;

  assign accept      = pix_i.valid && in_ready;
  assign pix_i.ready = in_ready;

  // size registers and clamping
  rgbds_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .restart_o  (restart),
    .src_w_o    (src_w),
    .src_h_o    (src_h),
    .dst_w_o    (dst_w),
    .dst_h_o    (dst_h)
  );

  // raster counters and keep decision
  rgbds_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (restart),
    .src_w_i   (src_w),
    .src_h_i   (src_h),
    .dst_w_i   (dst_w),
    .dst_h_i   (dst_h),
    .dec_o     (dec)
  );

  // color expansion and result register
  rgbds_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pix_i       (pix_i.data),
    .dec_i       (dec),
    .in_ready_o  (in_ready),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_data_o  (rgb_o.data)
  );

endmodule

`default_nettype wire

// ----- sv/rgbds_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rgbds_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // a pending result waits until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // a new result only follows an accepted pixel
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_acc))
    else $error("result without an accepted pixel");

  // an empty result register never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a taken result with no new request leaves the output empty
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !in_acc |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

bind rgb565_nearest_downscaler rgbds_chk u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_i.valid),
  .in_ready  (pix_i.ready),
  .out_valid (rgb_o.valid),
  .out_ready (rgb_o.ready)
);

`default_nettype wire
